@@ hdl/rph_pkg.sv @@
`timescale 1ns / 1ps

package rph_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int TIME_BITS  = 32;
    localparam int ID_BITS    = 8;
    localparam int IDX_BITS   = $clog2(HEAP_DEPTH);
    localparam int CNT_BITS   = $clog2(HEAP_DEPTH + 1);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_op                  op;
        logic [TIME_BITS-1:0] arrival_stamp;
        logic [TIME_BITS-1:0] deadline;
        logic [ID_BITS-1:0]   requester_id;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [TIME_BITS-1:0] out_arrival;
        logic [TIME_BITS-1:0] out_deadline;
        logic [ID_BITS-1:0]   out_requester;
        logic [CNT_BITS-1:0]  occupancy;
    } t_rsp;

    // One heap entry as it sits in the entry memory.
    typedef struct packed {
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] deadline;
        logic [ID_BITS-1:0]   requester;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    // Memory command from the sequencer: one write and two reads per cycle.
    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        t_entry              wdata;
        logic [IDX_BITS-1:0] raddr_a;
        logic [IDX_BITS-1:0] raddr_b;
    } t_mem_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD,
        S_POP_LD,
        S_DN_RD,
        S_DN_CMP,
        S_RESULT
    } t_state;

    // True when x is strictly ahead of y under the given mode.
    function automatic logic ranks_first(input t_entry x, input t_entry y, input logic mode);
        logic [TIME_BITS-1:0] kx;
        logic [TIME_BITS-1:0] ky;
        kx = mode ? x.deadline : x.arrival;
        ky = mode ? y.deadline : y.arrival;
        if (kx != ky) begin
            return kx < ky;
        end
        return x.requester < y.requester;
    endfunction

endpackage

@@ hdl/rph_ram.sv @@
`timescale 1ns / 1ps

module rph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ hdl/rph_seq.sv @@
`timescale 1ns / 1ps

module rph_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  rph_pkg::t_req     i_req,
    input  logic              i_mode,
    output rph_pkg::t_mem_cmd o_mem,
    input  rph_pkg::t_entry   i_rd_a,
    input  rph_pkg::t_entry   i_rd_b,
    output logic              o_strobe,
    output rph_pkg::t_rsp     o_rsp
);

    import rph_pkg::*;

    localparam int WIDE = IDX_BITS + 1;

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic [IDX_BITS-1:0] r_hole,  n_hole;
    t_entry              r_held,  n_held;
    t_entry              r_out,   n_out;
    t_status             r_status, n_status;
    logic                r_rv,    n_rv;

    logic                w_accept;
    logic                w_full;
    logic                w_empty;
    logic                w_last;
    logic [IDX_BITS-1:0] w_parent;
    logic                w_up_win;
    logic [WIDE-1:0]     w_l_wide;
    logic [WIDE-1:0]     w_r_wide;
    logic                w_l_in;
    logic                w_r_in;
    logic                w_l_first;
    logic                w_r_over_l;
    logic                w_r_over_held;
    logic                w_pick_r;
    logic                w_pick_l;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_full   = (r_count == CNT_BITS'(HEAP_DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_last   = (r_count == CNT_BITS'(1));

    // Sift-up: the held entry moves up while it beats its parent.
    assign w_parent = IDX_BITS'((r_hole - IDX_BITS'(1)) >> 1);
    assign w_up_win = ranks_first(r_held, i_rd_a, i_mode);

    // Sift-down: children of the hole; the right child is only looked at
    // when the left one exists, so its index cannot wrap.
    assign w_l_wide = {r_hole, 1'b1};
    assign w_r_wide = w_l_wide + WIDE'(1);
    assign w_l_in   = w_l_wide < WIDE'(r_count);
    assign w_r_in   = w_r_wide < WIDE'(r_count);

    assign w_l_first     = ranks_first(i_rd_a, r_held, i_mode);
    assign w_r_over_l    = ranks_first(i_rd_b, i_rd_a, i_mode);
    assign w_r_over_held = ranks_first(i_rd_b, r_held, i_mode);
    assign w_pick_r      = r_rv && (w_l_first ? w_r_over_l : w_r_over_held);
    assign w_pick_l      = w_l_first && !w_pick_r;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.op == OP_PUSH) begin
                        n_state = w_full ? S_RESULT : S_UP_RD;
                    end else begin
                        n_state = w_empty ? S_RESULT : S_POP_RD;
                    end
                end
            end
            S_UP_RD: begin
                n_state = (r_hole == '0) ? S_RESULT : S_UP_CMP;
            end
            S_UP_CMP: begin
                n_state = w_up_win ? S_UP_RD : S_RESULT;
            end
            S_POP_RD: begin
                n_state = S_POP_LD;
            end
            S_POP_LD: begin
                n_state = w_last ? S_RESULT : S_DN_RD;
            end
            S_DN_RD: begin
                n_state = w_l_in ? S_DN_CMP : S_RESULT;
            end
            S_DN_CMP: begin
                n_state = (w_pick_l || w_pick_r) ? S_DN_RD : S_RESULT;
            end
            S_RESULT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count        = r_count;
        n_hole         = r_hole;
        n_held         = r_held;
        n_out          = r_out;
        n_status       = r_status;
        n_rv           = r_rv;
        o_mem.we       = 1'b0;
        o_mem.waddr    = r_hole;
        o_mem.wdata    = r_held;
        o_mem.raddr_a  = '0;
        o_mem.raddr_b  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out    = '0;
                    n_status = ST_OK;
                    if (i_req.op == OP_PUSH) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_held.arrival   = i_req.arrival_stamp;
                            n_held.deadline  = i_req.deadline;
                            n_held.requester = i_req.requester_id;
                            n_hole           = r_count[IDX_BITS-1:0];
                            n_count          = r_count + CNT_BITS'(1);
                        end
                    end else if (w_empty) begin
                        n_status = ST_EMPTY;
                    end
                end
            end
            S_UP_RD: begin
                if (r_hole == '0) begin
                    o_mem.we = 1'b1;
                end else begin
                    o_mem.raddr_a = w_parent;
                end
            end
            S_UP_CMP: begin
                o_mem.we = 1'b1;
                if (w_up_win) begin
                    o_mem.wdata = i_rd_a;
                    n_hole      = w_parent;
                end
            end
            S_POP_RD: begin
                o_mem.raddr_b = IDX_BITS'(r_count - CNT_BITS'(1));
            end
            S_POP_LD: begin
                n_out   = i_rd_a;
                n_held  = i_rd_b;
                n_count = r_count - CNT_BITS'(1);
                n_hole  = '0;
            end
            S_DN_RD: begin
                if (w_l_in) begin
                    o_mem.raddr_a = w_l_wide[IDX_BITS-1:0];
                    o_mem.raddr_b = w_r_wide[IDX_BITS-1:0];
                    n_rv          = w_r_in;
                end else begin
                    o_mem.we = 1'b1;
                end
            end
            S_DN_CMP: begin
                o_mem.we = 1'b1;
                if (w_pick_r) begin
                    o_mem.wdata = i_rd_b;
                    n_hole      = w_r_wide[IDX_BITS-1:0];
                end else if (w_pick_l) begin
                    o_mem.wdata = i_rd_a;
                    n_hole      = w_l_wide[IDX_BITS-1:0];
                end
            end
            S_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_hole   <= n_hole;
        r_held   <= n_held;
        r_out    <= n_out;
        r_status <= n_status;
        r_rv     <= n_rv;
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_strobe            = (r_state == S_RESULT);
    assign o_rsp.status        = r_status;
    assign o_rsp.out_arrival   = r_out.arrival;
    assign o_rsp.out_deadline  = r_out.deadline;
    assign o_rsp.out_requester = r_out.requester;
    assign o_rsp.occupancy     = r_count;

endmodule

@@ hdl/request_priority_heap.sv @@
`timescale 1ns / 1ps

// Bounded min-heap of requests (arrival time, deadline, requester id).
// Command channel: a word on i_req is taken at a clock edge where start is
// high and busy is low. op selects push (insert and sift up) or pop (take
// the root, move the last entry to the root and sift it down).
// Result channel: one word per command on o_rsp, valid for exactly one
// cycle while o_strobe is high. The receiver cannot stall it, so it must
// sample o_rsp whenever o_strobe is high.
// Timing: a rejected push or an empty pop strobes in the cycle after it is
// taken. Otherwise each heap level costs a memory read and a compare with
// write-back. A push crosses at most log2(HEAP_DEPTH) levels and a pop at
// most log2(HEAP_DEPTH) - 1. Busy stays high through the strobe cycle, so
// a new command is only taken once the last result has been strobed.
// Configuration: scheduler_mode (0 arrival order, 1 earliest deadline) is
// written through i_cfg_valid / o_cfg_ready. The user must write it only
// while the block is idle; the block itself does not enforce this, as
// o_cfg_ready is always high.
// Reset: synchronous, active low. It empties the heap and clears the mode;
// the entry memory is not cleared, as only written slots are ever read.
module request_priority_heap (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rph_pkg::t_req i_req,
    output logic          o_strobe,
    output rph_pkg::t_rsp o_rsp,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);

    import rph_pkg::*;

    // Scheduling mode register; the user must write it only between commands (not enforced).
    logic r_mode;

    t_mem_cmd w_mem;
    t_entry   w_rd_a;
    t_entry   w_rd_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // All heap entries live in this memory; the sequencer keeps the moving
    // entry in a register and writes each displaced entry into the hole.
    rph_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_mem.we),
        .i_waddr   (w_mem.waddr),
        .i_wdata   (w_mem.wdata),
        .i_raddr_a (w_mem.raddr_a),
        .i_raddr_b (w_mem.raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    rph_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_req    (i_req),
        .i_mode   (r_mode),
        .o_mem    (w_mem),
        .i_rd_a   (w_rd_a),
        .i_rd_b   (w_rd_b),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    // A taken command always makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("command taken but block not busy");

    // Exactly one result cycle per command.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    // A rejected push only happens with the heap full.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_rsp.status == ST_FULL) |->
            (o_rsp.occupancy == CNT_BITS'(HEAP_DEPTH)))
        else $error("full status with free slots");

    // An empty pop only happens with nothing held.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_rsp.status == ST_EMPTY) |-> (o_rsp.occupancy == '0))
        else $error("empty status with entries held");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the request heap. Commands are queued by the
// stimulus process, handed to the block one word at a time by a clocked
// driver, and every accepted word is run through a software heap kept here
// in the bench. The monitor compares each strobed result word with the
// oldest prediction, one field at a time.
module tb_top;

    import rph_pkg::*;

    // The slowest correct run is roughly 1400 words plus the sender's idle
    // gaps. This limit sits well clear of that.
    localparam int CYCLE_LIMIT = 400000;
    // The tail after the last result allows for more than a full sift.
    localparam int DRAIN_CYCLES = 2 * IDX_BITS + 12;

    logic i_clk       = 1'b0;
    logic rst_n       = 1'b0;
    logic start       = 1'b0;
    t_req cmd_word    = '0;
    logic cfg_valid   = 1'b0;
    logic cfg_data    = 1'b0;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;
    logic o_cfg_ready;

    // Commands waiting for the driver, and result words still owed by the block.
    t_req cmd_backlog[$];
    t_rsp expected_rsp[$];

    // The bench's own copy of the heap, its fill level and the priority mode.
    t_entry model_heap [HEAP_DEPTH];
    int     model_count = 0;
    logic   model_mode  = 1'b0;

    int          send_gap_pct = 35;
    int unsigned cycle_count  = 0;
    int          error_count  = 0;
    int          issued_cmds  = 0;
    int          served_cmds  = 0;
    int          full_rejects = 0;
    int          empty_pops   = 0;
    int          mode_writes  = 0;

    request_priority_heap dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (cmd_word),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Priority order of the bench heap: the key picked by the mode decides,
    // and on equal keys the smaller requester id goes first.
    function automatic logic outranks(input t_entry a, input t_entry b);
        logic [TIME_BITS-1:0] key_a;
        logic [TIME_BITS-1:0] key_b;
        key_a = model_mode ? a.deadline : a.arrival;
        key_b = model_mode ? b.deadline : b.arrival;
        if (key_a != key_b) begin
            return key_a < key_b;
        end
        return a.requester < b.requester;
    endfunction

    function automatic void swap_slots(input int a, input int b);
        t_entry held;
        held          = model_heap[a];
        model_heap[a] = model_heap[b];
        model_heap[b] = held;
    endfunction

    // Applies one command to the bench heap and returns the result word the
    // block ought to strobe for it.
    function automatic t_rsp heap_apply(input t_req cmd);
        t_rsp   rsp;
        t_entry fresh;
        int     slot;
        int     parent;
        int     left;
        int     best;
        bit     settled;
        rsp        = '0;
        rsp.status = ST_OK;
        if (cmd.op == OP_PUSH) begin
            if (model_count >= HEAP_DEPTH) begin
                rsp.status = ST_FULL;
            end else begin
                fresh.arrival     = cmd.arrival_stamp;
                fresh.deadline    = cmd.deadline;
                fresh.requester   = cmd.requester_id;
                slot              = model_count;
                model_heap[slot]  = fresh;
                model_count++;
                settled = 1'b0;
                while (slot > 0 && !settled) begin
                    parent = (slot - 1) / 2;
                    if (outranks(model_heap[slot], model_heap[parent])) begin
                        swap_slots(slot, parent);
                        slot = parent;
                    end else begin
                        settled = 1'b1;
                    end
                end
            end
        end else if (model_count == 0) begin
            rsp.status = ST_EMPTY;
        end else begin
            rsp.out_arrival   = model_heap[0].arrival;
            rsp.out_deadline  = model_heap[0].deadline;
            rsp.out_requester = model_heap[0].requester;
            model_count--;
            if (model_count > 0) begin
                // The last entry takes the root and sinks to its place.
                model_heap[0] = model_heap[model_count];
                slot    = 0;
                settled = 1'b0;
                while (!settled) begin
                    left = 2 * slot + 1;
                    best = slot;
                    if (left < model_count && outranks(model_heap[left], model_heap[best])) begin
                        best = left;
                    end
                    if (left + 1 < model_count
                            && outranks(model_heap[left + 1], model_heap[best])) begin
                        best = left + 1;
                    end
                    if (best == slot) begin
                        settled = 1'b1;
                    end else begin
                        swap_slots(slot, best);
                        slot = best;
                    end
                end
            end
        end
        rsp.occupancy = model_count[CNT_BITS-1:0];
        return rsp;
    endfunction

    // Time stamps lean towards the extremes and towards a narrow band of small
    // values, so that equal keys, and hence the requester tie-break, are common.
    function automatic logic [TIME_BITS-1:0] random_stamp();
        case ($urandom_range(7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2, 3: begin
                return TIME_BITS'($urandom_range(15));
            end
            default: begin
                return TIME_BITS'($urandom);
            end
        endcase
    endfunction

    function automatic t_req random_request(input t_op op);
        t_req r;
        r.op            = op;
        r.arrival_stamp = random_stamp();
        r.deadline      = random_stamp();
        if ($urandom_range(3) == 0) begin
            r.requester_id = ID_BITS'($urandom_range(3));
        end else begin
            r.requester_id = ID_BITS'($urandom);
        end
        return r;
    endfunction

    task automatic queue_cmd(input t_op op, input logic [TIME_BITS-1:0] arrival,
                             input logic [TIME_BITS-1:0] deadline,
                             input logic [ID_BITS-1:0] requester);
        t_req r;
        r.op            = op;
        r.arrival_stamp = arrival;
        r.deadline      = deadline;
        r.requester_id  = requester;
        cmd_backlog.push_back(r);
    endtask

    // Random traffic is built from runs: mostly pushes, which drive the heap
    // into the full state, mostly pops, which drain it past empty, and an even
    // mix in between. Pop words carry random data in their ignored fields.
    task automatic random_traffic(input int n_cmds);
        int queued;
        int run_len;
        int push_pct;
        int k;
        queued = 0;
        @(negedge i_clk);
        while (queued < n_cmds) begin
            case ($urandom_range(2))
                0: begin
                    push_pct = 95;
                end
                1: begin
                    push_pct = 5;
                end
                default: begin
                    push_pct = 50;
                end
            endcase
            run_len = $urandom_range(30, 90);
            for (k = 0; k < run_len && queued < n_cmds; k++) begin
                if ($urandom_range(99) < push_pct) begin
                    cmd_backlog.push_back(random_request(OP_PUSH));
                end else begin
                    cmd_backlog.push_back(random_request(OP_POP));
                end
                queued++;
            end
        end
    endtask

    // Returns once every queued command has been taken and answered. Checked
    // on the falling edge, clear of the clocked processes.
    task automatic wait_drained();
        @(negedge i_clk);
        while (cmd_backlog.size() != 0 || expected_rsp.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Mode writes are only made with nothing in flight, so the bench heap
    // can switch its ordering at the same edge as the block does.
    task automatic write_mode(input logic value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!(cfg_valid && o_cfg_ready === 1'b1)) begin
            @(posedge i_clk);
        end
        model_mode = value;
        cfg_valid <= 1'b0;
        mode_writes++;
    endtask

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    // Command driver. A word is taken at an edge where start is high and busy
    // low; its prediction is made there and then. The next word is put up
    // straight away, even while the block is still busy, unless the sender
    // decides to sit out this cycle.
    always @(posedge i_clk) begin : cmd_driver
        bit taken;
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && busy === 1'b0;
            if (taken) begin
                expected_rsp.push_back(heap_apply(cmd_word));
                void'(cmd_backlog.pop_front());
                issued_cmds++;
            end
            if ((taken || !start) && cmd_backlog.size() != 0
                    && $urandom_range(99) >= send_gap_pct) begin
                start    <= 1'b1;
                cmd_word <= cmd_backlog[0];
            end else if (taken) begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor. The block cannot be held off, so every strobed word is
    // taken at the edge that ends its cycle.
    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        if (rst_n && o_strobe === 1'b1) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t ns: result word with none owed, expected none, got %h",
                         $time, o_rsp);
                error_count++;
            end else begin
                want = expected_rsp.pop_front();
                report_field("status", want.status, o_rsp.status);
                report_field("out_arrival", want.out_arrival, o_rsp.out_arrival);
                report_field("out_deadline", want.out_deadline, o_rsp.out_deadline);
                report_field("out_requester", want.out_requester, o_rsp.out_requester);
                report_field("occupancy", want.occupancy, o_rsp.occupancy);
                case (want.status)
                    ST_FULL: begin
                        full_rejects++;
                    end
                    ST_EMPTY: begin
                        empty_pops++;
                    end
                    default: begin
                        served_cmds++;
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d words still owed.",
                     cycle_count, expected_rsp.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        // Arrival order first. An empty pop, the extreme stamps and ids,
        // an arrival tie settled by id, and a full tie that must not swap.
        write_mode(1'b0);
        @(negedge i_clk);
        queue_cmd(OP_POP, '1, '1, '1);
        queue_cmd(OP_PUSH, '1, '0, '1);
        queue_cmd(OP_PUSH, '0, '1, '0);
        queue_cmd(OP_PUSH, 'h40, 'h40, 'h80);
        queue_cmd(OP_PUSH, 'h40, 'h40, 'h7f);
        queue_cmd(OP_PUSH, 'h40, 'h10, 'h7f);
        wait_drained();

        // Switch to deadline order with five entries still held: the stored
        // layout stays, and only later sifts follow the new order. The heap
        // is then emptied and popped once more past empty.
        write_mode(1'b1);
        @(negedge i_clk);
        queue_cmd(OP_PUSH, 'h1, 'h40, 'h01);
        queue_cmd(OP_PUSH, 'h2, '0, '0);
        repeat (8) begin
            queue_cmd(OP_POP, '0, '0, '0);
        end
        wait_drained();

        // Random phases. The sender idles often, then very often, then never,
        // and the mode flips between phases with whatever the heap then holds.
        send_gap_pct = 35;
        random_traffic(460);
        wait_drained();
        write_mode(1'b0);

        send_gap_pct = 70;
        random_traffic(460);
        wait_drained();
        write_mode(1'b1);

        send_gap_pct = 0;
        random_traffic(460);
        wait_drained();

        // Leave room for any stray strobe after the last owed word.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands through both priority modes with %0d mode writes.",
                 issued_cmds, mode_writes);
        $display("%0d served, %0d pushes refused when full, %0d pops on empty; %0d mismatches.",
                 served_cmds, full_rejects, empty_pops, error_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/rph_pkg.sv
hdl/rph_ram.sv
hdl/rph_seq.sv
hdl/request_priority_heap.sv
tb/tb_top.sv
